/* hdl/wrh_pkg.sv */
package wrh_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int DIVIDEND_BITS = 32;
   localparam int DIVISOR_BITS = 13;
   localparam int DIV_COUNT_BITS = 5;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] RST_AUDIO_FORMAT = 16'd1;
   localparam logic [31:0] RST_SAMPLE_RATE = 32'd48000;
   localparam logic [5:0] RST_BITS_PER_SAMPLE = 6'd16;
   localparam logic [15:0] RST_CHANNELS = 16'd1;
   localparam logic [7:0] RST_MAX_CHUNKS = 8'd32;

   localparam logic [2:0] REG_AUDIO_FORMAT = 3'd0;
   localparam logic [2:0] REG_SAMPLE_RATE = 3'd1;
   localparam logic [2:0] REG_BITS_PER_SAMPLE = 3'd2;
   localparam logic [2:0] REG_CHANNELS = 3'd3;
   localparam logic [2:0] REG_MAX_CHUNKS = 3'd4;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_NO_RIFF = 3'd1,
      ST_NO_WAVE = 3'd2,
      ST_NO_FMT = 3'd3,
      ST_FMT_SHORT = 3'd4,
      ST_NO_DATA = 3'd5,
      ST_TRUNCATED = 3'd6,
      ST_UNSUPPORTED = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_TAG = 3'd1,
      MODE_COUNT = 3'd2,
      MODE_HDR = 3'd3,
      MODE_FMT = 3'd4,
      MODE_SKIP = 3'd5
   } dp_mode_type;

   typedef struct packed {
      logic step;
      logic restart;
      dp_mode_type mode;
   } dp_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic tag_riff;
      logic tag_wave;
      logic tag_fmt;
      logic tag_data;
      logic len_short;
      logic limit_hit;
      logic skip_zero;
      logic skip_last;
   } dp_status_type;

   typedef struct packed {
      logic emit;
      status_type code;
      logic found;
      logic busy;
   } ctrl_out_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic first_byte;
      logic last_byte;
   } req_data_type;

   typedef struct packed {
      status_type status;
      logic [31:0] data_offset;
      logic [31:0] sample_count;
      logic [15:0] audio_format;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
   } rsp_data_type;

endpackage

/* hdl/wav_riff_header_parser.sv */
// RIFF/WAVE header parser.
// The req channel carries the file one byte per request; first_byte restarts
// the parse with that byte at offset zero and last_byte marks the file end.
// The rsp channel returns one result per parse: a status, the offset of the
// first sample byte, the sample count and the fields of the fmt chunk.
// Header bytes are taken one per cycle while no result waits on rsp_ready.
// A result caused by a rejected or truncated file is registered and
// presented in the cycle after the byte that caused it. When the data
// chunk is found, the sample count comes from a 32-step shift-subtract
// divider and req_ready stays low while it runs. Bytes after a result are
// taken and dropped until first_byte. A result waiting on rsp_ready holds
// req_ready low; the output register then frees in the cycle it is taken.
// The csr port holds the required format, channels, rate and bit depth and
// the per-search chunk limit; write it only while no parse is running.
// Reset returns the parser to waiting for the RIFF tag, drops any pending
// result and restores the register defaults.
module wav_riff_header_parser (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input wrh_pkg::req_data_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output wrh_pkg::rsp_data_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [wrh_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic [15:0] cfg_format_ff;
   logic [31:0] cfg_rate_ff;
   logic [5:0] cfg_bits_ff;
   logic [15:0] cfg_channels_ff;
   logic [7:0] cfg_max_chunks_ff;

   logic fire;
   logic csr_write;
   logic [2:0] csr_index;

   wrh_pkg::dp_cmd_type cmd;
   wrh_pkg::dp_status_type dp_status;
   wrh_pkg::ctrl_out_type ctrl_out;

   logic [31:0] length_full;
   logic [63:0] fmt_fields_next;
   logic [15:0] fmt_bits_next;
   logic [wrh_pkg::OFFSET_BITS-1:0] position_next;
   logic div_done;
   logic [31:0] quotient;
   logic [12:0] sample_bytes;
   logic format_match;

   logic rsp_valid_ff;
   wrh_pkg::rsp_data_type rsp_ff;
   logic bps_zero_ff;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_format_ff <= wrh_pkg::RST_AUDIO_FORMAT;
         cfg_rate_ff <= wrh_pkg::RST_SAMPLE_RATE;
         cfg_bits_ff <= wrh_pkg::RST_BITS_PER_SAMPLE;
         cfg_channels_ff <= wrh_pkg::RST_CHANNELS;
         cfg_max_chunks_ff <= wrh_pkg::RST_MAX_CHUNKS;
      end else if (csr_write) begin
         unique case (csr_index)
            wrh_pkg::REG_AUDIO_FORMAT: cfg_format_ff <= csr_pwdata[15:0];
            wrh_pkg::REG_SAMPLE_RATE: cfg_rate_ff <= csr_pwdata;
            wrh_pkg::REG_BITS_PER_SAMPLE: cfg_bits_ff <= csr_pwdata[5:0];
            wrh_pkg::REG_CHANNELS: cfg_channels_ff <= csr_pwdata[15:0];
            wrh_pkg::REG_MAX_CHUNKS: cfg_max_chunks_ff <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wrh_pkg::REG_AUDIO_FORMAT: csr_prdata = {16'd0, cfg_format_ff};
         wrh_pkg::REG_SAMPLE_RATE: csr_prdata = cfg_rate_ff;
         wrh_pkg::REG_BITS_PER_SAMPLE: csr_prdata = {26'd0, cfg_bits_ff};
         wrh_pkg::REG_CHANNELS: csr_prdata = {16'd0, cfg_channels_ff};
         wrh_pkg::REG_MAX_CHUNKS: csr_prdata = {24'd0, cfg_max_chunks_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   assign req_ready = !ctrl_out.busy && (!rsp_valid_ff || rsp_ready);
   assign fire = req_valid && req_ready;

   wrh_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .first_byte(req_data.first_byte),
      .last_byte(req_data.last_byte),
      .status(dp_status),
      .div_done(div_done),
      .cmd(cmd),
      .ctrl_out(ctrl_out)
   );

   wrh_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .byte_value(req_data.byte_value),
      .max_chunks(cfg_max_chunks_ff),
      .status(dp_status),
      .length_full(length_full),
      .fmt_fields_next(fmt_fields_next),
      .fmt_bits_next(fmt_bits_next),
      .position_next(position_next)
   );

   assign sample_bytes = fmt_bits_next[15:3];

   wrh_div u_div (
      .clock(clock),
      .reset(reset),
      .start(ctrl_out.found),
      .dividend(length_full),
      .divisor(sample_bytes),
      .done(div_done),
      .quotient(quotient)
   );

   assign format_match = (fmt_fields_next[15:0] == cfg_format_ff)
                      && (fmt_fields_next[31:16] == cfg_channels_ff)
                      && (fmt_fields_next[63:32] == cfg_rate_ff)
                      && (fmt_bits_next == {10'd0, cfg_bits_ff});

   always_ff @(posedge clock) begin
      if (ctrl_out.emit || ctrl_out.found) begin
         rsp_ff.audio_format <= fmt_fields_next[15:0];
         rsp_ff.channel_count <= fmt_fields_next[31:16];
         rsp_ff.sample_rate <= fmt_fields_next[63:32];
         rsp_ff.bits_per_sample <= fmt_bits_next;
         rsp_ff.sample_count <= '0;
      end
      if (ctrl_out.emit) begin
         rsp_ff.status <= ctrl_out.code;
         rsp_ff.data_offset <= '0;
      end else if (ctrl_out.found) begin
         rsp_ff.status <= format_match ? wrh_pkg::ST_OK : wrh_pkg::ST_UNSUPPORTED;
         rsp_ff.data_offset <= 32'(position_next);
         bps_zero_ff <= sample_bytes == '0;
      end
      if (div_done) begin
         rsp_ff.sample_count <= bps_zero_ff ? '0 : quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_out.emit || div_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* hdl/wrh_div.sv */
module wrh_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [wrh_pkg::DIVIDEND_BITS-1:0] dividend,
   input logic [wrh_pkg::DIVISOR_BITS-1:0] divisor,
   output logic done,
   output logic [wrh_pkg::DIVIDEND_BITS-1:0] quotient
);

   logic active_ff;
   logic done_ff;
   logic [wrh_pkg::DIV_COUNT_BITS-1:0] count_ff;
   logic [wrh_pkg::DIVIDEND_BITS-1:0] quo_ff;
   logic [wrh_pkg::DIVISOR_BITS-1:0] rem_ff;
   logic [wrh_pkg::DIVISOR_BITS-1:0] divisor_ff;
   logic [wrh_pkg::DIVISOR_BITS:0] rem_shift;
   logic [wrh_pkg::DIVISOR_BITS:0] rem_diff;
   logic fits;

   // One restoring step per cycle, most significant quotient bit first.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[wrh_pkg::DIVIDEND_BITS-1]};
      fits = rem_shift >= {1'b0, divisor_ff};
      rem_diff = rem_shift - {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= active_ff && (count_ff == '1);
         if (start) begin
            active_ff <= 1'b1;
            count_ff <= '0;
         end else if (active_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == '1) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         divisor_ff <= divisor;
      end else if (active_ff) begin
         quo_ff <= {quo_ff[wrh_pkg::DIVIDEND_BITS-2:0], fits};
         rem_ff <= fits ? rem_diff[wrh_pkg::DIVISOR_BITS-1:0]
                        : rem_shift[wrh_pkg::DIVISOR_BITS-1:0];
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/wrh_datapath.sv */
module wrh_datapath (
   input logic clock,
   input logic reset,
   input wrh_pkg::dp_cmd_type cmd,
   input logic [7:0] byte_value,
   input logic [7:0] max_chunks,
   output wrh_pkg::dp_status_type status,
   output logic [31:0] length_full,
   output logic [63:0] fmt_fields_next,
   output logic [15:0] fmt_bits_next,
   output logic [wrh_pkg::OFFSET_BITS-1:0] position_next
);

   logic [3:0] idx_ff, idx_in, idx_eff;
   logic [31:0] tag_ff, tag_in, tag_eff;
   logic [31:0] len_ff, len_in, len_eff;
   logic [32:0] skip_ff, skip_in, skip_eff;
   logic [7:0] chunks_ff, chunks_in, chunks_eff;
   logic [wrh_pkg::OFFSET_BITS-1:0] pos_ff, pos_in, pos_eff;
   logic [31:0] fmt_len_ff, fmt_len_in, fmt_len_eff;
   logic [63:0] fields_ff, fields_in, fields_eff;
   logic [15:0] bits_ff, bits_in, bits_eff;

   logic [31:0] tag_shift;
   logic [32:0] hdr_amount;
   logic [32:0] tail_amount;
   logic [7:0] chunks_next;
   logic [7:0] limit;

   always_comb begin
      // A restarting request sees the cleared parse state.
      idx_eff = cmd.restart ? '0 : idx_ff;
      tag_eff = cmd.restart ? '0 : tag_ff;
      len_eff = cmd.restart ? '0 : len_ff;
      skip_eff = cmd.restart ? '0 : skip_ff;
      chunks_eff = cmd.restart ? '0 : chunks_ff;
      pos_eff = cmd.restart ? '0 : pos_ff;
      fmt_len_eff = cmd.restart ? '0 : fmt_len_ff;
      fields_eff = cmd.restart ? '0 : fields_ff;
      bits_eff = cmd.restart ? '0 : bits_ff;

      tag_shift = {tag_eff[23:0], byte_value};
      length_full = {byte_value, len_eff[23:0]};
      hdr_amount = {1'b0, length_full} + {32'd0, length_full[0]};
      tail_amount = {1'b0, fmt_len_eff} - 33'd16 + {32'd0, fmt_len_eff[0]};
      chunks_next = (chunks_eff == 8'hFF) ? chunks_eff : chunks_eff + 8'd1;
      limit = (max_chunks == 8'd0) ? 8'd1 : max_chunks;

      status.tag_riff = tag_shift == wrh_pkg::TAG_RIFF;
      status.tag_wave = tag_shift == wrh_pkg::TAG_WAVE;
      status.tag_fmt = tag_eff == wrh_pkg::TAG_FMT;
      status.tag_data = tag_eff == wrh_pkg::TAG_DATA;
      status.len_short = length_full < 32'd16;
      status.limit_hit = chunks_next >= limit;
      status.skip_zero = (cmd.mode == wrh_pkg::MODE_FMT) ? (tail_amount == '0)
                                                          : (hdr_amount == '0);
      status.skip_last = skip_eff <= 33'd1;

      unique case (cmd.mode)
         wrh_pkg::MODE_TAG, wrh_pkg::MODE_COUNT: status.idx_last = idx_eff == 4'd3;
         wrh_pkg::MODE_HDR: status.idx_last = idx_eff == 4'd7;
         wrh_pkg::MODE_FMT: status.idx_last = idx_eff == 4'd15;
         default: status.idx_last = 1'b0;
      endcase

      idx_in = status.idx_last ? 4'd0 : idx_eff + 4'd1;
      tag_in = tag_eff;
      len_in = len_eff;
      skip_in = skip_eff;
      chunks_in = chunks_eff;
      pos_in = pos_eff + 1'b1;
      fmt_len_in = fmt_len_eff;
      fields_in = fields_eff;
      bits_in = bits_eff;

      unique case (cmd.mode)
         wrh_pkg::MODE_TAG: begin
            tag_in = status.idx_last ? '0 : tag_shift;
         end
         wrh_pkg::MODE_COUNT: begin
         end
         wrh_pkg::MODE_HDR: begin
            if (idx_eff < 4'd4) begin
               tag_in = tag_shift;
            end else begin
               len_in = len_eff | ({24'd0, byte_value} << {idx_eff[1:0], 3'b000});
            end
            if (status.idx_last) begin
               tag_in = '0;
               len_in = '0;
               skip_in = hdr_amount;
               fmt_len_in = length_full;
               chunks_in = chunks_next;
            end
         end
         wrh_pkg::MODE_FMT: begin
            if (idx_eff < 4'd8) begin
               fields_in = fields_eff | ({56'd0, byte_value} << {idx_eff[2:0], 3'b000});
            end else if (idx_eff == 4'd14) begin
               bits_in[7:0] = byte_value;
            end else if (idx_eff == 4'd15) begin
               bits_in[15:8] = byte_value;
            end
            if (status.idx_last) begin
               tag_in = '0;
               len_in = '0;
               chunks_in = '0;
               skip_in = tail_amount;
            end
         end
         wrh_pkg::MODE_SKIP: begin
            idx_in = '0;
            if (skip_eff != '0) begin
               skip_in = skip_eff - 33'd1;
            end
         end
         default: begin
            idx_in = idx_eff;
            pos_in = pos_eff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         tag_ff <= '0;
         len_ff <= '0;
         skip_ff <= '0;
         chunks_ff <= '0;
         pos_ff <= '0;
         fmt_len_ff <= '0;
         fields_ff <= '0;
         bits_ff <= '0;
      end else if (cmd.step) begin
         idx_ff <= idx_in;
         tag_ff <= tag_in;
         len_ff <= len_in;
         skip_ff <= skip_in;
         chunks_ff <= chunks_in;
         pos_ff <= pos_in;
         fmt_len_ff <= fmt_len_in;
         fields_ff <= fields_in;
         bits_ff <= bits_in;
      end
   end

   assign fmt_fields_next = cmd.step ? fields_in : fields_eff;
   assign fmt_bits_next = cmd.step ? bits_in : bits_eff;
   assign position_next = pos_in;

endmodule

/* hdl/wrh_ctrl.sv */
module wrh_ctrl (
   input logic clock,
   input logic reset,
   input logic fire,
   input logic first_byte,
   input logic last_byte,
   input wrh_pkg::dp_status_type status,
   input logic div_done,
   output wrh_pkg::dp_cmd_type cmd,
   output wrh_pkg::ctrl_out_type ctrl_out
);

   typedef enum logic [10:0] {
      S_RIFF = 11'b000_0000_0001,
      S_RSIZE = 11'b000_0000_0010,
      S_WAVE = 11'b000_0000_0100,
      S_HDR_FMT = 11'b000_0000_1000,
      S_FMT_BODY = 11'b000_0001_0000,
      S_SKIP_FMT = 11'b000_0010_0000,
      S_SKIP_TAIL = 11'b000_0100_0000,
      S_HDR_DATA = 11'b000_1000_0000,
      S_SKIP_DATA = 11'b001_0000_0000,
      S_DIVIDE = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in, phase_eff;

   always_comb begin
      cmd.restart = fire && first_byte;
      phase_eff = cmd.restart ? S_RIFF : state_ff;
      cmd.step = fire && (phase_eff != S_DONE) && (phase_eff != S_DIVIDE);

      unique case (phase_eff)
         S_RIFF, S_WAVE: cmd.mode = wrh_pkg::MODE_TAG;
         S_RSIZE: cmd.mode = wrh_pkg::MODE_COUNT;
         S_HDR_FMT, S_HDR_DATA: cmd.mode = wrh_pkg::MODE_HDR;
         S_FMT_BODY: cmd.mode = wrh_pkg::MODE_FMT;
         S_SKIP_FMT, S_SKIP_TAIL, S_SKIP_DATA: cmd.mode = wrh_pkg::MODE_SKIP;
         default: cmd.mode = wrh_pkg::MODE_IDLE;
      endcase

      state_in = phase_eff;
      ctrl_out.emit = 1'b0;
      ctrl_out.code = wrh_pkg::ST_OK;
      ctrl_out.found = 1'b0;
      ctrl_out.busy = state_ff == S_DIVIDE;

      if (cmd.step) begin
         unique case (phase_eff)
            S_RIFF: begin
               if (status.idx_last) begin
                  if (status.tag_riff) begin
                     state_in = S_RSIZE;
                  end else begin
                     ctrl_out.emit = 1'b1;
                     ctrl_out.code = wrh_pkg::ST_NO_RIFF;
                  end
               end
            end
            S_RSIZE: begin
               if (status.idx_last) begin
                  state_in = S_WAVE;
               end
            end
            S_WAVE: begin
               if (status.idx_last) begin
                  if (status.tag_wave) begin
                     state_in = S_HDR_FMT;
                  end else begin
                     ctrl_out.emit = 1'b1;
                     ctrl_out.code = wrh_pkg::ST_NO_WAVE;
                  end
               end
            end
            S_HDR_FMT: begin
               if (status.idx_last) begin
                  if (status.tag_fmt) begin
                     if (status.len_short) begin
                        ctrl_out.emit = 1'b1;
                        ctrl_out.code = wrh_pkg::ST_FMT_SHORT;
                     end else begin
                        state_in = S_FMT_BODY;
                     end
                  end else if (status.limit_hit) begin
                     ctrl_out.emit = 1'b1;
                     ctrl_out.code = wrh_pkg::ST_NO_FMT;
                  end else begin
                     state_in = status.skip_zero ? S_HDR_FMT : S_SKIP_FMT;
                  end
               end
            end
            S_FMT_BODY: begin
               if (status.idx_last) begin
                  state_in = status.skip_zero ? S_HDR_DATA : S_SKIP_TAIL;
               end
            end
            S_HDR_DATA: begin
               if (status.idx_last) begin
                  if (status.tag_data) begin
                     ctrl_out.found = 1'b1;
                     state_in = S_DIVIDE;
                  end else if (status.limit_hit) begin
                     ctrl_out.emit = 1'b1;
                     ctrl_out.code = wrh_pkg::ST_NO_DATA;
                  end else begin
                     state_in = status.skip_zero ? S_HDR_DATA : S_SKIP_DATA;
                  end
               end
            end
            S_SKIP_FMT: begin
               if (status.skip_last) begin
                  state_in = S_HDR_FMT;
               end
            end
            S_SKIP_TAIL, S_SKIP_DATA: begin
               if (status.skip_last) begin
                  state_in = S_HDR_DATA;
               end
            end
            default: begin
               state_in = S_RIFF;
            end
         endcase

         // The file ended before the parse reached a verdict.
         if (!ctrl_out.emit && !ctrl_out.found && last_byte) begin
            ctrl_out.emit = 1'b1;
            ctrl_out.code = wrh_pkg::ST_TRUNCATED;
         end
         if (ctrl_out.emit) begin
            state_in = S_DONE;
         end
      end

      if (state_ff == S_DIVIDE && div_done) begin
         state_in = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RIFF;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/wrh_checker.sv */
module wrh_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input wrh_pkg::rsp_data_type rsp_data
);

   // Reset drops any pending result.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result still valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // A result that is not taken keeps new requests out.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   // Failures other than an unsupported format carry no offset and no sample count.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != wrh_pkg::ST_OK
         && rsp_data.status != wrh_pkg::ST_UNSUPPORTED
      |-> rsp_data.data_offset == 32'd0 && rsp_data.sample_count == 32'd0)
      else $error("failure result with nonzero offset or count");

endmodule

bind wav_riff_header_parser wrh_checker u_checker (.*);
